FILE: rtl/audio_ring_upsample_mixer_unit_assert.svh
// ----------------------------------------------------------------------------
// Audio ring upsample mixer assertion macros
// Shared macros for the concurrent assertions of the audio ring mixer.
// ----------------------------------------------------------------------------
`ifndef AUDIO_RING_UPSAMPLE_MIXER_UNIT_ASSERT_SVH
`define AUDIO_RING_UPSAMPLE_MIXER_UNIT_ASSERT_SVH

// Assertion that is switched off while reset is held.
`define ARUM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is also checked while reset is held.
`define ARUM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/arum_pkg.sv
// ----------------------------------------------------------------------------
// Audio ring upsample mixer package
// Types, codes and sizes shared by the modules of the audio ring mixer.
// ----------------------------------------------------------------------------
package arum_pkg;

    localparam int RING_DEPTH_DEF = 65536;

    localparam int SAMPLE_W = 8;
    localparam int MIX_W    = 32;
    localparam int FILL_W   = 16;
    localparam int VOLUME_W = 13;
    localparam int HELD_W   = 16;
    localparam int CFG_W    = VOLUME_W;

    localparam logic [VOLUME_W-1:0] VOLUME_RESET = VOLUME_W'(1843);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] MODE_PUSH  = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_FLUSH = 2'd2;

    localparam logic CFG_VOLUME  = 1'b0;
    localparam logic CFG_PLAYING = 1'b1;

    typedef enum logic [1:0] {
        OP_PASS  = 2'd0,
        OP_POP   = 2'd1,
        OP_HOLD  = 2'd2,
        OP_FLUSH = 2'd3
    } t_arum_op;

    typedef struct packed {
        logic [1:0]                mode;
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [MIX_W-1:0]    mix_in;
        logic                      block_start;
    } t_arum_in;

    typedef struct packed {
        logic signed [MIX_W-1:0] mix_out;
        logic                    accepted;
        logic                    underrun;
        logic [FILL_W-1:0]       fill_level;
    } t_arum_out;

    typedef struct packed {
        t_arum_op                   op;
        logic signed [MIX_W-1:0]    mix_in;
        logic                       accepted;
        logic                       underrun;
        logic [FILL_W-1:0]          fill_level;
        logic signed [SAMPLE_W-1:0] sample;
    } t_arum_cmd;

    typedef struct packed {
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_arum_qstat;

endpackage

FILE: rtl/audio_ring_upsample_mixer_unit.sv
// ----------------------------------------------------------------------------
// Audio ring upsample mixer
// One audio channel: a sample ring feeding a 2x sample-and-hold into a mix bus.
// ----------------------------------------------------------------------------
// Every item gives exactly one result, in order. Items are taken one per clock
// cycle while full is low. Each item is registered with its ring read, waits in
// the command queue, is registered with its volume multiply and passes the
// saturating mix add into the result queue. The front end and the back end are
// parted by a four-entry command queue and the results wait in a four-entry
// result queue; full rises once the front register and the command queue hold
// four items. The ring is one memory of RING_DEPTH bytes with one write and one
// registered read port per cycle and needs no clearing after reset.
module audio_ring_upsample_mixer_unit #(
    parameter int RING_DEPTH = arum_pkg::RING_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    input  arum_pkg::t_arum_in          i_item,
    output logic                        full,
    output logic                        empty,
    input  logic                        pop,
    output arum_pkg::t_arum_out         o_result,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [arum_pkg::CFG_W-1:0]  i_cfg_data
);
    import arum_pkg::*;

    logic [VOLUME_W-1:0] r_volume;
    logic                r_playing;

    t_arum_cmd           w_front_cmd;
    logic                w_cmd_push;
    logic [$bits(t_arum_cmd)-1:0] w_cmd_data;
    t_arum_cmd           w_cmd;
    t_arum_qstat         w_cmd_stat;
    logic                w_cmd_pop;
    t_arum_out           w_res;
    logic                w_res_push;
    logic [$bits(t_arum_out)-1:0] w_res_data;
    t_arum_qstat         w_res_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume  <= VOLUME_RESET;
            r_playing <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_VOLUME:  r_volume  <= i_cfg_data[VOLUME_W-1:0];
                CFG_PLAYING: r_playing <= i_cfg_data[0];
                default:     r_playing <= r_playing;
            endcase
        end
    end

    arum_front #(
        .RING_DEPTH (RING_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .i_playing  (r_playing),
        .i_cmd_stat (w_cmd_stat),
        .o_full     (full),
        .o_cmd_push (w_cmd_push),
        .o_cmd      (w_front_cmd)
    );

    arum_queue #(
        .WIDTH ($bits(t_arum_cmd))
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  (w_front_cmd),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd_data),
        .o_stat  (w_cmd_stat)
    );

    assign w_cmd = t_arum_cmd'(w_cmd_data);

    arum_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_cmd_stat (w_cmd_stat),
        .i_res_stat (w_res_stat),
        .i_volume   (r_volume),
        .o_cmd_pop  (w_cmd_pop),
        .o_res_push (w_res_push),
        .o_res      (w_res)
    );

    arum_queue #(
        .WIDTH ($bits(t_arum_out))
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .i_pop   (pop),
        .o_data  (w_res_data),
        .o_stat  (w_res_stat)
    );

    assign o_result = t_arum_out'(w_res_data);
    assign empty    = w_res_stat.empty;

endmodule

FILE: rtl/arum_queue.sv
// ----------------------------------------------------------------------------
// Audio ring mixer queue
// Small first-in first-out buffer with an occupancy count.
// ----------------------------------------------------------------------------
module arum_queue #(
    parameter int WIDTH = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [WIDTH-1:0]     i_data,
    input  logic                 i_pop,
    output logic [WIDTH-1:0]     o_data,
    output arum_pkg::t_arum_qstat o_stat
);
    import arum_pkg::*;

    logic [WIDTH-1:0]  r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_pop;

    assign w_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.count = r_count;

endmodule

FILE: rtl/arum_front.sv
// ----------------------------------------------------------------------------
// Audio ring mixer front end
// Accepts items, keeps the sample ring and its indices, and classifies ticks.
// ----------------------------------------------------------------------------
module arum_front #(
    parameter int RING_DEPTH = arum_pkg::RING_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  arum_pkg::t_arum_in    i_item,
    input  logic                  i_playing,
    input  arum_pkg::t_arum_qstat i_cmd_stat,
    output logic                  o_full,
    output logic                  o_cmd_push,
    output arum_pkg::t_arum_cmd   o_cmd
);
    import arum_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);

    logic [SAMPLE_W-1:0] r_ring [RING_DEPTH];
    logic [SAMPLE_W-1:0] r_rd_data;
    logic [AW-1:0]       r_wr_idx;
    logic [AW-1:0]       r_rd_idx;
    logic                r_phase;
    logic                r_stopped;
    logic                r_f1_valid;
    t_arum_cmd           r_f1;

    logic [AW-1:0]       n_wr_idx;
    logic [AW-1:0]       n_rd_idx;
    logic                n_phase;
    logic                n_stopped;
    t_arum_cmd           n_f1;

    logic                w_acc;
    logic                w_we;
    logic                w_re;
    logic [AW-1:0]       w_fill;
    logic [AW-1:0]       w_fill_next;
    logic [31:0]         w_fill_ext;
    logic [QCNT_W:0]     w_occupied;

    assign w_occupied  = (QCNT_W + 1)'(i_cmd_stat.count) + (QCNT_W + 1)'(r_f1_valid);
    assign o_full      = (w_occupied >= (QCNT_W + 1)'(QUEUE_DEPTH));
    assign w_acc       = i_push && !o_full;
    assign w_fill      = r_wr_idx - r_rd_idx;
    assign w_fill_next = n_wr_idx - n_rd_idx;
    assign w_fill_ext  = 32'(w_fill_next);

    always_comb begin
        n_wr_idx    = r_wr_idx;
        n_rd_idx    = r_rd_idx;
        n_phase     = r_phase;
        n_stopped   = r_stopped;
        w_we        = 1'b0;
        w_re        = 1'b0;
        n_f1        = '0;
        n_f1.op     = OP_PASS;
        n_f1.mix_in = i_item.mix_in;
        case (i_item.mode)
            MODE_PUSH: begin
                if (i_playing && (w_fill != {AW{1'b1}})) begin
                    w_we          = 1'b1;
                    n_wr_idx      = r_wr_idx + 1'b1;
                    n_f1.accepted = 1'b1;
                end
            end
            MODE_TICK: begin
                if (i_playing) begin
                    n_stopped = r_stopped && !i_item.block_start;
                    if (n_stopped) begin
                        n_f1.underrun = 1'b1;
                    end else if (!r_phase) begin
                        if (w_fill == '0) begin
                            n_stopped     = 1'b1;
                            n_f1.underrun = 1'b1;
                        end else begin
                            w_re     = 1'b1;
                            n_rd_idx = r_rd_idx + 1'b1;
                            n_phase  = 1'b1;
                            n_f1.op  = OP_POP;
                        end
                    end else begin
                        n_phase = 1'b0;
                        n_f1.op = OP_HOLD;
                    end
                end
            end
            MODE_FLUSH: begin
                n_wr_idx  = '0;
                n_rd_idx  = '0;
                n_phase   = 1'b0;
                n_stopped = 1'b0;
                n_f1.op   = OP_FLUSH;
            end
            default: begin
                n_f1.op = OP_PASS;
            end
        endcase
        n_f1.fill_level = w_fill_ext[FILL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_we) begin
            r_ring[r_wr_idx] <= i_item.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_re) begin
            r_rd_data <= r_ring[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_f1 <= n_f1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx   <= '0;
            r_rd_idx   <= '0;
            r_phase    <= 1'b0;
            r_stopped  <= 1'b0;
            r_f1_valid <= 1'b0;
        end else begin
            r_f1_valid <= w_acc;
            if (w_acc) begin
                r_wr_idx  <= n_wr_idx;
                r_rd_idx  <= n_rd_idx;
                r_phase   <= n_phase;
                r_stopped <= n_stopped;
            end
        end
    end

    always_comb begin
        o_cmd        = r_f1;
        o_cmd.sample = r_rd_data;
    end

    assign o_cmd_push = r_f1_valid;

endmodule

FILE: rtl/arum_back.sv
// ----------------------------------------------------------------------------
// Audio ring mixer back end
// Scales popped samples by the volume, keeps the held value and mixes it in.
// ----------------------------------------------------------------------------
module arum_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  arum_pkg::t_arum_cmd           i_cmd,
    input  arum_pkg::t_arum_qstat         i_cmd_stat,
    input  arum_pkg::t_arum_qstat         i_res_stat,
    input  logic [arum_pkg::VOLUME_W-1:0] i_volume,
    output logic                          o_cmd_pop,
    output logic                          o_res_push,
    output arum_pkg::t_arum_out           o_res
);
    import arum_pkg::*;

    localparam int PROD_W = SAMPLE_W + VOLUME_W + 1;

    logic                     r_b1_valid;
    t_arum_cmd                r_b1;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [HELD_W-1:0] r_held;

    logic signed [VOLUME_W:0]   w_vol;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [PROD_W-5:0]   w_scaled;
    logic signed [HELD_W-1:0]   w_new_held;
    logic signed [HELD_W-1:0]   w_addend;
    logic signed [MIX_W:0]      w_sum;
    logic signed [MIX_W-1:0]    w_sum_sat;
    logic [QCNT_W:0]            w_res_used;

    assign w_res_used = (QCNT_W + 1)'(i_res_stat.count) + (QCNT_W + 1)'(r_b1_valid);
    assign o_cmd_pop  = !i_cmd_stat.empty && (w_res_used < (QCNT_W + 1)'(QUEUE_DEPTH));

    assign w_vol  = {1'b0, i_volume};
    assign w_prod = i_cmd.sample * w_vol;

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_b1   <= i_cmd;
            r_prod <= w_prod;
        end
    end

    // Sample times 256 times volume over 4096 is the product shifted down by four.
    assign w_scaled = r_prod[PROD_W-1:4];

    always_comb begin
        if (w_scaled[PROD_W-5:HELD_W-1] == '0 ||
            w_scaled[PROD_W-5:HELD_W-1] == '1) begin
            w_new_held = w_scaled[HELD_W-1:0];
        end else if (w_scaled[PROD_W-5]) begin
            w_new_held = {1'b1, {(HELD_W-1){1'b0}}};
        end else begin
            w_new_held = {1'b0, {(HELD_W-1){1'b1}}};
        end
    end

    assign w_addend = (r_b1.op == OP_POP) ? w_new_held : r_held;
    assign w_sum    = (MIX_W + 1)'(r_b1.mix_in) + (MIX_W + 1)'(w_addend);

    always_comb begin
        if (w_sum[MIX_W] == w_sum[MIX_W-1]) begin
            w_sum_sat = w_sum[MIX_W-1:0];
        end else if (w_sum[MIX_W]) begin
            w_sum_sat = {1'b1, {(MIX_W-1){1'b0}}};
        end else begin
            w_sum_sat = {1'b0, {(MIX_W-1){1'b1}}};
        end
    end

    always_comb begin
        o_res.accepted   = r_b1.accepted;
        o_res.underrun   = r_b1.underrun;
        o_res.fill_level = r_b1.fill_level;
        case (r_b1.op)
            OP_POP:  o_res.mix_out = w_sum_sat;
            OP_HOLD: o_res.mix_out = w_sum_sat;
            default: o_res.mix_out = r_b1.mix_in;
        endcase
    end

    assign o_res_push = r_b1_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_held     <= '0;
        end else begin
            r_b1_valid <= o_cmd_pop;
            if (r_b1_valid) begin
                case (r_b1.op)
                    OP_POP:   r_held <= w_new_held;
                    OP_FLUSH: r_held <= '0;
                    default:  r_held <= r_held;
                endcase
            end
        end
    end

endmodule

FILE: rtl/arum_checker.sv
// ----------------------------------------------------------------------------
// Audio ring mixer port checker
// Checks what the ports of the audio ring mixer show over time.
// ----------------------------------------------------------------------------
`include "audio_ring_upsample_mixer_unit_assert.svh"

module arum_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input arum_pkg::t_arum_out o_result
);
    import arum_pkg::*;

    `ARUM_ASSERT_ALWAYS(a_empty_after_reset, i_clk, !i_rst_n |=> empty, "result side not empty after reset")

    `ARUM_ASSERT_ALWAYS(a_not_full_after_reset, i_clk, !i_rst_n |=> !full, "input side full after reset")

    `ARUM_ASSERT(a_result_kind, i_clk, i_rst_n, !empty |-> !(o_result.accepted && o_result.underrun), "result both stored a sample and reported an underrun")

    `ARUM_ASSERT(a_result_held, i_clk, i_rst_n, (!empty && !pop) |=> (!empty && $stable(o_result)), "waiting result changed before its transfer")

endmodule

bind audio_ring_upsample_mixer_unit arum_checker u_arum_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);

FILE: test/tb_audio_ring_upsample_mixer_unit.sv
// ----------------------------------------------------------------------------
// Audio ring upsample mixer testbench
// Drives push, tick, flush and unused-mode items into the channel, predicts
// each result with a local model of the sample ring and the 2x sample-and-hold
// mixer, and checks every result transfer field by field in order. Directed
// cases cover the register extremes, underrun and stopped blocks, saturation
// and flush; random traffic, receiver back-pressure and a back-to-back push
// burst that is drained past empty follow.
// ----------------------------------------------------------------------------
module tb_audio_ring_upsample_mixer_unit;

    import arum_pkg::*;

    localparam logic [1:0] MODE_SPARE  = 2'd3;
    localparam int         HOLD_CYCLES = 60;
    localparam int         CYCLE_LIMIT = 600000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    t_arum_in           i_item = '0;
    logic               full;
    logic               empty;
    logic               pop = 1'b0;
    t_arum_out          o_result;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_index = 1'b0;
    logic [CFG_W-1:0]   i_cfg_data = '0;

    logic signed [SAMPLE_W-1:0] ring_mem [0:65535];
    logic [15:0]                wr_ptr = '0;
    logic [15:0]                rd_ptr = '0;
    logic                       phase = 1'b0;
    logic signed [HELD_W-1:0]   held_val = '0;
    logic                       stopped = 1'b0;
    logic [VOLUME_W-1:0]        ch_volume = VOLUME_RESET;
    logic                       ch_playing = 1'b0;

    t_arum_out awaited_results[$];
    int        mismatches = 0;
    int        results_checked = 0;
    int        items_sent = 0;
    int        cycle_count = 0;
    bit        idle_on = 1'b1;
    bit        hold_request = 1'b0;

    audio_ring_upsample_mixer_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_item      (i_item),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** audio_ring_upsample_mixer_unit: FAILED **");
            $finish;
        end
    end

    function automatic t_arum_out compute_channel_result(input t_arum_in it);
        t_arum_out res;
        longint    prod;
        longint    held;
        longint    sum;
        logic      play;
        res.mix_out    = it.mix_in;
        res.accepted   = 1'b0;
        res.underrun   = 1'b0;
        case (it.mode)
            MODE_PUSH: begin
                if (ch_playing && 16'(wr_ptr - rd_ptr) != 16'hFFFF) begin
                    ring_mem[wr_ptr] = it.sample;
                    wr_ptr           = wr_ptr + 16'd1;
                    res.accepted     = 1'b1;
                end
            end
            MODE_TICK: begin
                if (ch_playing) begin
                    play = 1'b1;
                    if (it.block_start) begin
                        stopped = 1'b0;
                    end
                    if (stopped) begin
                        res.underrun = 1'b1;
                        play         = 1'b0;
                    end else if (!phase) begin
                        if (wr_ptr == rd_ptr) begin
                            stopped      = 1'b1;
                            res.underrun = 1'b1;
                            play         = 1'b0;
                        end else begin
                            prod = longint'($signed(ring_mem[rd_ptr])) * 256
                                   * longint'(ch_volume);
                            held = prod >>> 12;
                            if (held > 32767) begin
                                held = 32767;
                            end else if (held < -32768) begin
                                held = -32768;
                            end
                            held_val = held[15:0];
                            rd_ptr   = rd_ptr + 16'd1;
                            phase    = 1'b1;
                        end
                    end else begin
                        phase = 1'b0;
                    end
                    if (play) begin
                        sum = longint'($signed(it.mix_in)) + longint'(held_val);
                        if (sum > 64'sd2147483647) begin
                            sum = 64'sd2147483647;
                        end else if (sum < -64'sd2147483648) begin
                            sum = -64'sd2147483648;
                        end
                        res.mix_out = sum[31:0];
                    end
                end
            end
            MODE_FLUSH: begin
                wr_ptr   = '0;
                rd_ptr   = '0;
                phase    = 1'b0;
                held_val = '0;
                stopped  = 1'b0;
            end
            default: begin
            end
        endcase
        res.fill_level = 16'(wr_ptr - rd_ptr);
        return res;
    endfunction

    function automatic t_arum_in make_item(input logic [1:0] m, input logic [7:0] s,
                                           input logic [31:0] mx, input logic bs);
        t_arum_in it;
        it.mode        = m;
        it.sample      = s;
        it.mix_in      = mx;
        it.block_start = bs;
        return it;
    endfunction

    function automatic logic [31:0] random_mix();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return 32'h7FFF_FFFF - 32'($urandom_range(0, 40000));
        end else if (pick == 1) begin
            return 32'h8000_0000 + 32'($urandom_range(0, 40000));
        end
        return $urandom;
    endfunction

    always @(posedge i_clk) begin : result_check
        t_arum_out want;
        static int hold_left = 0;
        static int stall_left = 0;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                results_checked++;
                if (awaited_results.size() == 0) begin
                    $error("result transfer with no expectation waiting");
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    if (o_result.mix_out !== want.mix_out) begin
                        $error("mix_out: expected %0d, got %0d",
                               want.mix_out, o_result.mix_out);
                        mismatches++;
                    end
                    if (o_result.accepted !== want.accepted) begin
                        $error("accepted: expected %0d, got %0d",
                               want.accepted, o_result.accepted);
                        mismatches++;
                    end
                    if (o_result.underrun !== want.underrun) begin
                        $error("underrun: expected %0d, got %0d",
                               want.underrun, o_result.underrun);
                        mismatches++;
                    end
                    if (o_result.fill_level !== want.fill_level) begin
                        $error("fill_level: expected %0d, got %0d",
                               want.fill_level, o_result.fill_level);
                        mismatches++;
                    end
                end
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 2);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    task automatic send_item(input t_arum_in it);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 3);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        awaited_results.push_back(compute_channel_result(it));
        items_sent++;
    endtask

    task automatic wait_for_results();
        push <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_VOLUME) begin
            ch_volume = data;
        end else begin
            ch_playing = data[0];
        end
    endtask

    task automatic set_channel(input logic [CFG_W-1:0] vol, input logic play);
        wait_for_results();
        write_register(CFG_VOLUME, vol);
        write_register(CFG_PLAYING, {12'($urandom), play});
    endtask

    task automatic run_random_traffic(input int n_items);
        int start;
        int pick;
        int count;
        start = items_sent;
        while (items_sent - start < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                send_item(make_item(MODE_FLUSH, 8'($urandom), $urandom, 1'($urandom)));
            end else if (pick < 8) begin
                send_item(make_item(MODE_SPARE, 8'($urandom), $urandom, 1'($urandom)));
            end else if (pick < 14) begin
                send_item(make_item(2'($urandom), 8'($urandom), random_mix(),
                                    1'($urandom)));
            end else begin
                count = $urandom_range(0, 6);
                repeat (count) begin
                    send_item(make_item(MODE_PUSH, 8'($urandom), $urandom, 1'($urandom)));
                end
                count = $urandom_range(1, 10);
                send_item(make_item(MODE_TICK, 8'($urandom), random_mix(), 1'b1));
                repeat (count - 1) begin
                    send_item(make_item(MODE_TICK, 8'($urandom), random_mix(),
                                        $urandom_range(0, 7) == 0));
                end
            end
        end
    endtask

    task automatic test_directed();
        send_item(make_item(MODE_PUSH, 8'sd127, 32'd0, 1'b0));
        send_item(make_item(MODE_TICK, 8'd0, 32'd5, 1'b1));
        send_item(make_item(MODE_SPARE, 8'hA5, 32'h1234_5678, 1'b1));
        set_channel(13'd4096, 1'b1);
        send_item(make_item(MODE_TICK, 8'd0, 32'd100, 1'b1));
        send_item(make_item(MODE_TICK, 8'd0, 32'd200, 1'b0));
        send_item(make_item(MODE_PUSH, 8'h80, 32'd0, 1'b0));
        send_item(make_item(MODE_PUSH, 8'h7F, 32'd0, 1'b0));
        send_item(make_item(MODE_PUSH, 8'h00, 32'd0, 1'b0));
        send_item(make_item(MODE_TICK, 8'd0, 32'd300, 1'b0));
        send_item(make_item(MODE_TICK, 8'd0, 32'h8000_0000, 1'b1));
        send_item(make_item(MODE_TICK, 8'd0, 32'h8000_0005, 1'b0));
        send_item(make_item(MODE_TICK, 8'd0, 32'h7FFF_FFF0, 1'b0));
        send_item(make_item(MODE_TICK, 8'd0, 32'h7FFF_FFFF, 1'b0));
        send_item(make_item(MODE_SPARE, 8'h5A, 32'hDEAD_BEEF, 1'b0));
        send_item(make_item(MODE_FLUSH, 8'd0, 32'd0, 1'b0));
        send_item(make_item(MODE_TICK, 8'd0, 32'd7, 1'b1));
        set_channel(13'd8191, 1'b1);
        send_item(make_item(MODE_PUSH, 8'h7F, 32'd0, 1'b0));
        send_item(make_item(MODE_PUSH, 8'h80, 32'd0, 1'b0));
        repeat (4) send_item(make_item(MODE_TICK, 8'd0, $urandom, 1'b1));
        set_channel(13'd0, 1'b1);
        send_item(make_item(MODE_PUSH, 8'sd55, 32'd0, 1'b0));
        send_item(make_item(MODE_TICK, 8'd0, $urandom, 1'b1));
        send_item(make_item(MODE_FLUSH, 8'd0, 32'd0, 1'b0));
    endtask

    task automatic test_random_mix();
        logic [CFG_W-1:0] vols [7];
        vols = '{13'd0, 13'd4096, 13'd8191, 13'd1843, 13'd2048, 13'd1, 13'd6000};
        for (int p = 0; p < 7; p++) begin
            set_channel(p == 4 ? 13'($urandom) : vols[p], p != 3);
            run_random_traffic(170);
        end
    endtask

    task automatic test_backpressure();
        set_channel(13'd3000, 1'b1);
        @(posedge i_clk);
        hold_request = 1'b1;
        @(posedge i_clk);
        run_random_traffic(24);
        wait_for_results();
    endtask

    task automatic test_push_burst();
        idle_on = 1'b0;
        set_channel(13'd4096, 1'b1);
        send_item(make_item(MODE_FLUSH, 8'd0, 32'd0, 1'b0));
        repeat (12) send_item(make_item(MODE_PUSH, 8'($urandom), $urandom, 1'b0));
        send_item(make_item(MODE_TICK, 8'd0, random_mix(), 1'b1));
        repeat (25) send_item(make_item(MODE_TICK, 8'd0, random_mix(), 1'b0));
        send_item(make_item(MODE_FLUSH, 8'd0, 32'd0, 1'b0));
        idle_on = 1'b1;
    endtask

    task automatic test_quiet_finish();
        idle_on = 1'b0;
        set_channel(13'($urandom), 1'b1);
        run_random_traffic(150);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_mix();
        test_backpressure();
        test_push_burst();
        test_quiet_finish();
        wait_for_results();
        repeat (6) @(posedge i_clk);
        $display("Checked %0d result transfers against %0d item transfers: directed,",
                 results_checked, items_sent);
        $display("random traffic, receiver back-pressure and a push burst drained past empty.");
        if (mismatches == 0) begin
            $display("** audio_ring_upsample_mixer_unit: PASSED **");
        end else begin
            $display("** audio_ring_upsample_mixer_unit: FAILED **");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/arum_pkg.sv
rtl/arum_queue.sv
rtl/arum_front.sv
rtl/arum_back.sv
rtl/audio_ring_upsample_mixer_unit.sv
rtl/arum_checker.sv
test/tb_audio_ring_upsample_mixer_unit.sv
